@@ hdl/ohlc_pkg.sv @@
// ----------------------------------------------------------------------------
// ohlc_pkg: shared codes and layout for the OHLC candle aggregator
// Operation codes, register indexes, reset values and stream bit positions.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    // Operation carried in s_axis_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_CANDLE_SECONDS = 1'b0;
    localparam logic REG_HISTORY_LIMIT  = 1'b1;

    localparam logic [16:0] CANDLE_SECONDS_RST = 17'd60;
    localparam logic [6:0]  HISTORY_LIMIT_RST  = 7'd64;

    // Stream layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 3;
    localparam int M_COUNT_LSB = 160;
    localparam int USER_DONE  = 0;
    localparam int USER_VALID = 1;
    localparam int USER_NEW   = 2;

endpackage

@@ hdl/ohlc_candle_aggregator_top.sv @@
// ----------------------------------------------------------------------------
// ohlc_candle_aggregator_top: open/high/low/close candle builder with history
// Timing: a result is registered in the finish state after the input transfer,
//   held there while the result stream stalls; an aligned-start sample first runs
//   the 32-step bit-serial remainder. A new item is taken only once the last one is
//   done (read of the candle memory, then write back in the finish state).
// Reset: synchronous, active low; clears control, counters and registers to
//   their defaults. The candle memory is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module ohlc_candle_aggregator_top #(
    parameter int CANDLE_SLOTS = 64,
    parameter int PRICE_BITS   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_time[31:0], price[63:32], age_index[69:64], zero pad [71:70]
    input  logic [ohlc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic                           s_axis_tuser,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // candle_open[31:0], candle_high[63:32], candle_low[95:64],
    // candle_close[127:96], candle_start[159:128], stored_count[166:160], pad
    output logic [ohlc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // candle_done[0], entry_valid[1], new_candle[2]
    output logic [ohlc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SW = $clog2(CANDLE_SLOTS);
    localparam int IW = (SW > 6 ? SW : 6) + 1;
    localparam int PB = PRICE_BITS;
    localparam int EW = 4 * PB + 32;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} t_state;
    typedef enum logic [1:0] {K_READ, K_UPD, K_NEW} t_kind;

    t_state          r_state;
    t_kind           r_kind;
    logic [16:0]     r_candle_seconds;
    logic [6:0]      r_history_limit;
    logic [SW-1:0]   r_newest;
    logic [6:0]      r_kept;
    logic [32:0]     r_end;
    logic [31:0]     r_time;
    logic [PB-1:0]   r_price;
    logic            r_hit;
    logic            r_age_nz;
    logic [16:0]     r_div_rem;
    logic [31:0]     r_div_sh;
    logic [4:0]      r_div_cnt;
    logic [EW-1:0]   r_mem [CANDLE_SLOTS];
    logic [EW-1:0]   r_rd_data;
    logic            r_m_valid;
    logic [ohlc_pkg::M_TDATA_W-1:0] r_m_data;
    logic [ohlc_pkg::M_TUSER_W-1:0] r_m_user;

    logic            in_accept;
    logic            in_op;
    logic [31:0]     in_time;
    logic [63:0]     in_price_ext;
    logic [PB-1:0]   in_price;
    logic [5:0]      in_age;
    logic [16:0]     eff_len;
    logic [6:0]      eff_lim;
    logic [6:0]      kept_dec;
    logic [IW-1:0]   age_diff;
    logic [SW-1:0]   age_slot;
    logic            age_hit;
    logic            is_new;
    logic [SW-1:0]   next_slot;
    logic [SW-1:0]   rd_addr;
    logic [17:0]     div_trial;
    logic            div_ge;
    logic [16:0]     div_next;
    logic [31:0]     new_start;
    logic [PB-1:0]   rd_open;
    logic [PB-1:0]   rd_high;
    logic [PB-1:0]   rd_low;
    logic [PB-1:0]   rd_close;
    logic [31:0]     rd_start;
    logic [PB-1:0]   upd_high;
    logic [PB-1:0]   upd_low;
    logic            out_free;
    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    logic [EW-1:0]   mem_wd;
    logic [PB-1:0]   res_open;
    logic [PB-1:0]   res_high;
    logic [PB-1:0]   res_low;
    logic [PB-1:0]   res_close;
    logic [31:0]     res_start;
    logic [63:0]     ext_open;
    logic [63:0]     ext_high;
    logic [63:0]     ext_low;
    logic [63:0]     ext_close;
    logic [6:0]      res_count;
    logic            res_valid;
    logic            res_done;
    logic [ohlc_pkg::M_TDATA_W-1:0] res_data;
    logic [ohlc_pkg::M_TUSER_W-1:0] res_user;

    // Unpack the input transfer
    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign in_op        = s_axis_tuser;
    assign in_time      = s_axis_tdata[31:0];
    assign in_price_ext = 64'(s_axis_tdata[63:32]);
    assign in_price     = in_price_ext[PB-1:0];
    assign in_age       = s_axis_tdata[69:64];

    // Effective length and history limit
    assign eff_len  = (r_candle_seconds == '0) ? 17'd1 : r_candle_seconds;
    always_comb begin
        priority if (r_history_limit == '0) begin
            eff_lim = 7'd1;
        end else if (32'(r_history_limit) > CANDLE_SLOTS) begin
            eff_lim = 7'(CANDLE_SLOTS);
        end else begin
            eff_lim = r_history_limit;
        end
    end
    assign kept_dec = (r_kept >= eff_lim) ? r_kept - 7'd1 : r_kept;

    // Slot lookup by age, wrapping around the ring
    assign age_diff = IW'(r_newest) - IW'(in_age);
    assign age_slot = age_diff[IW-1] ? SW'(age_diff + IW'(CANDLE_SLOTS)) : SW'(age_diff);
    assign age_hit  = {1'b0, in_age} < r_kept;
    assign is_new   = (r_kept == '0) || ({1'b0, in_time} >= r_end);
    assign next_slot = (r_newest == SW'(CANDLE_SLOTS - 1)) ? '0 : r_newest + SW'(1);
    assign rd_addr  = (in_op == ohlc_pkg::OP_READ) ? age_slot : r_newest;

    // One restoring remainder step per cycle
    assign div_trial = {r_div_rem, r_div_sh[31]};
    assign div_ge    = div_trial >= {1'b0, eff_len};
    assign div_next  = div_ge ? 17'(div_trial - {1'b0, eff_len}) : div_trial[16:0];
    assign new_start = (kept_dec == '0) ? r_time - 32'(r_div_rem) : r_end[31:0];

    // Fields of the entry read at the input transfer
    assign rd_open  = r_rd_data[PB-1:0];
    assign rd_high  = r_rd_data[2*PB-1:PB];
    assign rd_low   = r_rd_data[3*PB-1:2*PB];
    assign rd_close = r_rd_data[4*PB-1:3*PB];
    assign rd_start = r_rd_data[EW-1:4*PB];
    assign upd_high = (r_price > rd_high) ? r_price : rd_high;
    assign upd_low  = (r_price < rd_low) ? r_price : rd_low;

    // Write back once the result can be registered
    assign out_free = !r_m_valid || m_axis_tready;
    assign mem_we   = (r_state == S_FIN) && out_free && (r_kind != K_READ);
    assign mem_wa   = (r_kind == K_NEW) ? next_slot : r_newest;
    assign mem_wd   = (r_kind == K_NEW) ? {new_start, r_price, r_price, r_price, r_price}
                                        : {rd_start, r_price, upd_low, upd_high, rd_open};

    // Build the result
    always_comb begin
        unique case (r_kind)
            K_READ: begin
                res_open  = r_hit ? rd_open : '0;
                res_high  = r_hit ? rd_high : '0;
                res_low   = r_hit ? rd_low : '0;
                res_close = r_hit ? rd_close : '0;
                res_start = r_hit ? rd_start : '0;
                res_valid = r_hit;
                res_done  = r_hit && r_age_nz;
                res_count = r_kept;
            end
            K_UPD: begin
                res_open  = rd_open;
                res_high  = upd_high;
                res_low   = upd_low;
                res_close = r_price;
                res_start = rd_start;
                res_valid = 1'b1;
                res_done  = 1'b0;
                res_count = r_kept;
            end
            K_NEW: begin
                res_open  = r_price;
                res_high  = r_price;
                res_low   = r_price;
                res_close = r_price;
                res_start = new_start;
                res_valid = 1'b1;
                res_done  = 1'b0;
                res_count = kept_dec + 7'd1;
            end
            default: begin
                res_open  = '0;
                res_high  = '0;
                res_low   = '0;
                res_close = '0;
                res_start = '0;
                res_valid = 1'b0;
                res_done  = 1'b0;
                res_count = r_kept;
            end
        endcase
    end

    assign ext_open  = 64'(res_open);
    assign ext_high  = 64'(res_high);
    assign ext_low   = 64'(res_low);
    assign ext_close = 64'(res_close);
    assign res_data  = {1'b0, res_count, res_start, ext_close[31:0], ext_low[31:0],
                        ext_high[31:0], ext_open[31:0]};
    assign res_user  = {(r_kind == K_NEW), res_valid, res_done};

    // Candle memory: one read at the input transfer, one write at finish
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // Control, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_kind           <= K_READ;
            r_m_valid        <= 1'b0;
            r_newest         <= '0;
            r_kept           <= '0;
            r_end            <= '0;
            r_div_cnt        <= '0;
            r_candle_seconds <= ohlc_pkg::CANDLE_SECONDS_RST;
            r_history_limit  <= ohlc_pkg::HISTORY_LIMIT_RST;
        end else begin
            // Register write
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    ohlc_pkg::REG_CANDLE_SECONDS: r_candle_seconds <= pwdata[16:0];
                    ohlc_pkg::REG_HISTORY_LIMIT:  r_history_limit  <= pwdata[6:0];
                    default: ;
                endcase
            end

            // Raise the result at finish, drop it once transferred
            if ((r_state == S_FIN) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_time   <= in_time;
                        r_price  <= in_price;
                        r_hit    <= age_hit;
                        r_age_nz <= (in_age != '0);
                        if (in_op == ohlc_pkg::OP_READ) begin
                            r_kind  <= K_READ;
                            r_state <= S_FIN;
                        end else if (is_new) begin
                            r_kind <= K_NEW;
                            // Aligned start needs the remainder of time by length
                            if (kept_dec == '0) begin
                                r_div_sh  <= in_time;
                                r_div_rem <= '0;
                                r_div_cnt <= '0;
                                r_state   <= S_DIV;
                            end else begin
                                r_state   <= S_FIN;
                            end
                        end else begin
                            r_kind  <= K_UPD;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    r_div_rem <= div_next;
                    r_div_sh  <= {r_div_sh[30:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_m_data  <= res_data;
                        r_m_user  <= res_user;
                        r_state   <= S_IDLE;
                        if (r_kind == K_NEW) begin
                            r_newest <= next_slot;
                            r_kept   <= kept_dec + 7'd1;
                            r_end    <= 33'(new_start) + 33'(eff_len);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == ohlc_pkg::REG_HISTORY_LIMIT) ? 32'(r_history_limit)
                                                                    : 32'(r_candle_seconds);

endmodule

@@ hdl/ohlc_checker.sv @@
// ----------------------------------------------------------------------------
// ohlc_checker: port-level checks for the OHLC candle aggregator
// Watches the result stream and its flag and count fields over time.
// ----------------------------------------------------------------------------
module ohlc_checker #(
    parameter int CANDLE_SLOTS = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ohlc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [ohlc_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A fresh candle is valid, current and counted
    a_new_candle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[ohlc_pkg::USER_NEW] |->
            m_axis_tuser[ohlc_pkg::USER_VALID] && !m_axis_tuser[ohlc_pkg::USER_DONE] &&
            (m_axis_tdata[ohlc_pkg::M_COUNT_LSB+6:ohlc_pkg::M_COUNT_LSB] != 7'd0))
        else $error("new candle flags inconsistent");

    // A missing entry reports zeros and no flags
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[ohlc_pkg::USER_VALID] |->
            (m_axis_tdata[ohlc_pkg::M_COUNT_LSB-1:0] == '0) &&
            !m_axis_tuser[ohlc_pkg::USER_DONE] && !m_axis_tuser[ohlc_pkg::USER_NEW])
        else $error("missing entry not zeroed");

    // A completed candle implies at least two kept, never above capacity
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[ohlc_pkg::USER_DONE] |->
            (m_axis_tdata[ohlc_pkg::M_COUNT_LSB+6:ohlc_pkg::M_COUNT_LSB] >= 7'd2) &&
            (32'(m_axis_tdata[ohlc_pkg::M_COUNT_LSB+6:ohlc_pkg::M_COUNT_LSB])
                <= CANDLE_SLOTS))
        else $error("completed candle with bad count");

endmodule

bind ohlc_candle_aggregator_top ohlc_checker #(
    .CANDLE_SLOTS(CANDLE_SLOTS)
) u_ohlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the OHLC candle aggregator
// Drives price samples and history reads over the input stream, programs the
// candle length and history limit over APB, and predicts every result with a
// behavioral candle history kept in the bench. Results are compared field by
// field in arrival order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CANDLE_SLOTS = 64;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [31:0] TIME_BASE    = 32'hFF00_0000;

    typedef struct packed {
        logic [31:0] open_px;
        logic [31:0] high_px;
        logic [31:0] low_px;
        logic [31:0] close_px;
        logic [31:0] start_s;
    } t_candle;

    typedef struct packed {
        t_candle     bar;
        logic        done;
        logic        valid;
        logic        fresh;
        logic [6:0]  count;
    } t_candle_report;

    // Clock, reset and DUT-facing signals
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic [ohlc_pkg::S_TDATA_W-1:0]   s_data = '0;
    logic                             s_user = ohlc_pkg::OP_SAMPLE;
    logic                             m_ready = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [2:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;

    logic                             s_axis_tready;
    logic                             m_axis_tvalid;
    logic [ohlc_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [ohlc_pkg::M_TUSER_W-1:0]   m_axis_tuser;
    logic [31:0]                      prdata;
    logic                             pready;

    // Predicted block state
    t_candle                candle_hist [CANDLE_SLOTS];
    logic [5:0]             newest_idx = '0;
    logic [6:0]             kept_cnt = '0;
    logic [32:0]            candle_end = '0;
    logic [16:0]            cfg_seconds = ohlc_pkg::CANDLE_SECONDS_RST;
    logic [6:0]             cfg_limit = ohlc_pkg::HISTORY_LIMIT_RST;

    t_candle_report         expected_reports [$];

    // Bench control and statistics
    bit                     no_idle = 1'b0;
    int                     hold_cycles = 0;
    int                     fail_count = 0;
    int                     cycle_count = 0;
    int                     n_samples = 0;
    int                     n_reads = 0;
    int                     n_opened = 0;
    int                     n_settings = 0;
    int                     results_checked = 0;

    ohlc_candle_aggregator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Effective candle length: zero acts as one second
    function automatic logic [32:0] candle_length();
        return (cfg_seconds == '0) ? 33'd1 : {16'd0, cfg_seconds};
    endfunction

    // Advance the predicted history by one item and return the expected report
    function automatic t_candle_report apply_item(input logic op, input logic [31:0] t,
                                                  input logic [31:0] p, input logic [5:0] age);
        t_candle_report rep;
        logic [5:0]     slot;
        logic [6:0]     lim;
        logic [32:0]    len;
        logic [32:0]    aligned;
        logic [31:0]    start;
        rep = '0;
        if (op == ohlc_pkg::OP_READ) begin
            if ({1'b0, age} < kept_cnt) begin
                slot      = newest_idx - age;
                rep.bar   = candle_hist[slot];
                rep.done  = (age != '0);
                rep.valid = 1'b1;
            end
            rep.count = kept_cnt;
            return rep;
        end
        len = candle_length();
        lim = (cfg_limit == '0) ? 7'd1 : ((cfg_limit > 7'd64) ? 7'd64 : cfg_limit);
        if (kept_cnt == '0 || {1'b0, t} >= candle_end) begin
            // open a candle, dropping at most one oldest entry
            if (kept_cnt >= lim)
                kept_cnt = kept_cnt - 7'd1;
            if (kept_cnt == '0) begin
                aligned = ({1'b0, t} / len) * len;
                start   = aligned[31:0];
            end else begin
                start = candle_end[31:0];
            end
            newest_idx = newest_idx + 6'd1;
            candle_hist[newest_idx].open_px  = p;
            candle_hist[newest_idx].high_px  = p;
            candle_hist[newest_idx].low_px   = p;
            candle_hist[newest_idx].close_px = p;
            candle_hist[newest_idx].start_s  = start;
            candle_end = {1'b0, start} + len;
            kept_cnt   = kept_cnt + 7'd1;
            rep.fresh  = 1'b1;
        end else begin
            if (p > candle_hist[newest_idx].high_px)
                candle_hist[newest_idx].high_px = p;
            if (p < candle_hist[newest_idx].low_px)
                candle_hist[newest_idx].low_px = p;
            candle_hist[newest_idx].close_px = p;
        end
        rep.bar   = candle_hist[newest_idx];
        rep.valid = 1'b1;
        rep.count = kept_cnt;
        return rep;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("t=%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Send one item; valid stays high afterwards unless a gap or drain lowers it
    task automatic send_item(input logic op, input logic [31:0] t, input logic [31:0] p,
                             input logic [5:0] age);
        t_candle_report rep;
        if (!no_idle && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {2'b00, age, p, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rep = apply_item(op, t, p, age);
        expected_reports.insert(expected_reports.size(), rep);
        if (op == ohlc_pkg::OP_READ)
            n_reads++;
        else
            n_samples++;
        if (rep.fresh)
            n_opened++;
    endtask

    // Lower valid and wait until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == ohlc_pkg::REG_CANDLE_SECONDS)
            cfg_seconds = value[16:0];
        else
            cfg_limit = value[6:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        check_field("register readback", value, readback);
    endtask

    // Reprogram both registers once the block has gone idle
    task automatic configure(input logic [16:0] seconds, input logic [6:0] limit);
        drain_results();
        repeat (4) @(posedge i_clk);
        write_register(ohlc_pkg::REG_CANDLE_SECONDS, {15'd0, seconds});
        write_register(ohlc_pkg::REG_HISTORY_LIMIT, {25'd0, limit});
        n_settings++;
    endtask

    // Mostly well-formed tick streams around the current candle, plus noise
    task automatic run_random_traffic(input int n_items);
        int          pick;
        int          len_i;
        logic [31:0] p;
        logic [31:0] t;
        logic [32:0] t33;
        logic [5:0]  age;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(9);
            p = (pick == 0) ? 32'd0 : ((pick == 1) ? 32'hFFFF_FFFF : $urandom);
            pick  = $urandom_range(99);
            len_i = int'(candle_length());
            if (pick < 30) begin
                if (kept_cnt == '0 || $urandom_range(3) == 0)
                    age = 6'($urandom_range(63));
                else
                    age = 6'($urandom_range(kept_cnt - 1));
                send_item(ohlc_pkg::OP_READ, $urandom, p, age);
            end else begin
                if (pick < 70)
                    t33 = candle_end - 33'($urandom_range(len_i, 1));
                else if (pick < 80)
                    t33 = candle_end;
                else if (pick < 90)
                    t33 = candle_end + 33'($urandom_range(20 * len_i, len_i));
                else
                    t33 = {1'b0, $urandom};
                t = (t33 > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : t33[31:0];
                send_item(ohlc_pkg::OP_SAMPLE, t, p, 6'($urandom));
            end
        end
    endtask

    // First candle and every candle under a one-entry history align afresh
    task automatic test_aligned_start();
        configure(17'd7, 7'd1);
        send_item(ohlc_pkg::OP_READ, 32'd0, 32'd0, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, TIME_BASE + 32'd100, 32'd1000, 6'h3F);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] - 32'd1, 32'hFFFF_FFFF, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] - 32'd1, 32'd0, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0], 32'd5000, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] + 32'd500, 32'd6000, 6'd0);
        send_item(ohlc_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_item(ohlc_pkg::OP_READ, 32'd0, 32'd0, 6'd1);
    endtask

    // Candles chained at the previous end, late samples, reads by age
    task automatic test_history_reads();
        configure(17'd60, 7'd64);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0], 32'd100, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] - 32'd30, 32'd300, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] - 32'd1, 32'd50, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] + 32'd60000, 32'd70, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0], 32'd80, 6'd0);
        for (int a = 0; a < 5; a++)
            send_item(ohlc_pkg::OP_READ, 32'd0, 32'd0, 6'(a));
        send_item(ohlc_pkg::OP_READ, 32'd0, 32'd0, 6'd63);
    endtask

    // Zero length acts as one second, zero limit as one entry
    task automatic test_zero_settings();
        configure(17'd0, 7'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0], 32'd11, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0], 32'd22, 6'd0);
        send_item(ohlc_pkg::OP_SAMPLE, candle_end[31:0] - 32'd1, 32'd33, 6'd0);
        send_item(ohlc_pkg::OP_READ, 32'd0, 32'd0, 6'd1);
    endtask

    // Random streams under several settings, extremes and a lowered limit
    task automatic test_random_settings();
        configure(17'd60, 7'd64);
        run_random_traffic(120);
        configure(17'd86400, 7'd5);
        run_random_traffic(60);
        configure(17'd1, 7'd64);
        run_random_traffic(100);
        configure(17'd131071, 7'd127);
        run_random_traffic(50);
        configure(17'd13, 7'd1);
        run_random_traffic(80);
    endtask

    // Hold off the result side long enough that the input stalls
    task automatic test_output_backpressure();
        configure(17'd7, 7'd20);
        hold_cycles = HOLD_CYCLES;
        run_random_traffic(40);
    endtask

    // Long stretch with neither side idling
    task automatic test_back_to_back();
        configure(17'd60, 7'd64);
        no_idle = 1'b1;
        run_random_traffic(100);
        drain_results();
        no_idle = 1'b0;
    endtask

    // Align a candle just below 2^32, then chain past it so every sample updates
    task automatic test_end_overrun();
        configure(17'd131071, 7'd1);
        send_item(ohlc_pkg::OP_SAMPLE, 32'hFFFF_0000, $urandom, 6'd0);
        configure(17'd131071, 7'd64);
        while (candle_end <= 33'h0_FFFF_FFFF)
            send_item(ohlc_pkg::OP_SAMPLE, 32'hFFFF_FFFF, $urandom, 6'($urandom));
        run_random_traffic(20);
    endtask

    // Result-side ready: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 12);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_candle_report want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $display("t=%0t unexpected result: expected none, actual %h / %h",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("candle_open", want.bar.open_px, m_axis_tdata[31:0]);
                check_field("candle_high", want.bar.high_px, m_axis_tdata[63:32]);
                check_field("candle_low", want.bar.low_px, m_axis_tdata[95:64]);
                check_field("candle_close", want.bar.close_px, m_axis_tdata[127:96]);
                check_field("candle_start", want.bar.start_s, m_axis_tdata[159:128]);
                check_field("stored_count", {25'd0, want.count},
                            {25'd0, m_axis_tdata[ohlc_pkg::M_COUNT_LSB +: 7]});
                check_field("candle_done", {31'd0, want.done},
                            {31'd0, m_axis_tuser[ohlc_pkg::USER_DONE]});
                check_field("entry_valid", {31'd0, want.valid},
                            {31'd0, m_axis_tuser[ohlc_pkg::USER_VALID]});
                check_field("new_candle", {31'd0, want.fresh},
                            {31'd0, m_axis_tuser[ohlc_pkg::USER_NEW]});
                results_checked++;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_tests
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_aligned_start();
        test_history_reads();
        test_zero_settings();
        test_random_settings();
        test_output_backpressure();
        test_back_to_back();
        test_end_overrun();
        drain_results();
        repeat (40) @(posedge i_clk);
        $display("covered %0d price ticks (%0d opened a candle) and %0d history reads",
                 n_samples, n_opened, n_reads);
        $display("across %0d register settings; %0d results compared, %0d mismatches",
                 n_settings, results_checked, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ohlc_pkg.sv
hdl/ohlc_candle_aggregator_top.sv
hdl/ohlc_checker.sv
tb/sv/testbench.sv
